// ===== hdl/mlfq_pkg.sv =====
`default_nettype none
package mlfq_pkg;

    localparam int NUM_LEVELS = 4;
    localparam int LVL_W      = 2;
    localparam int BASE_W     = 27;
    localparam int PCT_W      = 7;
    localparam int COST_W     = 29;
    localparam int CPU_W      = 48;
    localparam int CLK_W      = 63;

    localparam logic [BASE_W-1:0] BASE_RESET = 27'd10000000;
    localparam logic [BASE_W-1:0] BASE_MAX   = 27'd100000000;
    localparam logic [PCT_W-1:0]  PCT_MAX    = 7'd100;
    localparam logic [CPU_W-1:0]  CPU_MAX    = {CPU_W{1'b1}};
    localparam logic [CLK_W-1:0]  CLK_MAX    = {CLK_W{1'b1}};

    // floor(x/100) by reciprocal: exact for x < 2^30 and x < 2^15 respectively
    localparam logic [29:0] RECIP_FULL    = 30'd687194768;
    localparam int          RECIP_FULL_SH = 36;
    localparam logic [13:0] RECIP_REM     = 14'd10486;
    localparam int          RECIP_REM_SH  = 20;
    localparam logic [6:0]  HUNDRED       = 7'd100;

    typedef enum logic [1:0] {
        ACT_ADMIT    = 2'd0,
        ACT_SLICE    = 2'd1,
        ACT_IODONE   = 2'd2,
        ACT_DISPATCH = 2'd3
    } action_t;

    localparam logic [1:0] OC_TERM  = 2'd0;
    localparam logic [1:0] OC_WHOLE = 2'd1;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_FULL        = 3'd1,
        STAT_NONE_READY  = 3'd2,
        STAT_BUSY        = 3'd3,
        STAT_NONE_RUN    = 3'd4,
        STAT_NOT_BLOCKED = 3'd5,
        STAT_BAD_SLOT    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_FIFO,
        FSM_SLOT,
        FSM_COST,
        FSM_FIN
    } fsm_t;

    typedef struct packed {
        logic              start;
        logic              whole;
        logic [LVL_W-1:0]  lvl;
        logic [PCT_W-1:0]  pct;
        logic [BASE_W-1:0] base;
    } cost_req_t;

endpackage
`default_nettype wire

// ===== hdl/mlfq_ram.sv =====
`default_nettype none
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire                      rd_en,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// ===== hdl/mlfq_cost.sv =====
`default_nettype none
module mlfq_cost
    import mlfq_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  cost_req_t        req,
    output logic             done,
    output logic [COST_W-1:0] cost
);
    localparam int Q1_W = 23;
    localparam int RP_W = 14;

    logic [4:0]        vld_reg;
    logic              whole_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [COST_W-1:0] full_reg;
    logic [Q1_W-1:0]   q1_reg;
    logic [PCT_W-1:0]  r_reg;
    logic [COST_W-1:0] q1p_reg;
    logic [RP_W-1:0]   rp_reg;
    logic [COST_W-1:0] cost_reg;

    logic [BASE_W+2:0] full_w;
    logic [58:0]       q1_prod;
    logic [27:0]       q2_prod;

    always_comb begin
        full_w  = (BASE_W+3)'(req.base) * (BASE_W+3)'({1'b0, req.lvl} + 3'd1);
        q1_prod = 59'(full_reg) * 59'(RECIP_FULL);
        q2_prod = 28'(rp_reg) * 28'(RECIP_REM);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], req.start};
        end
    end

    // full slice, full/100, remainder and (full/100)*pct, remainder*pct, final sum (or full slice when whole)
    always_ff @(posedge aclk) begin
        if (req.start) begin
            full_reg  <= COST_W'(full_w);
            pct_reg   <= req.pct;
            whole_reg <= req.whole;
        end
        if (vld_reg[0]) begin
            q1_reg <= Q1_W'(q1_prod >> RECIP_FULL_SH);
        end
        if (vld_reg[1]) begin
            r_reg   <= PCT_W'(full_reg - COST_W'(q1_reg) * COST_W'(HUNDRED));
            q1p_reg <= COST_W'(q1_reg) * COST_W'(pct_reg);
        end
        if (vld_reg[2]) begin
            rp_reg <= RP_W'(r_reg) * RP_W'(pct_reg);
        end
        if (vld_reg[3]) begin
            cost_reg <= whole_reg ? full_reg
                                  : q1p_reg + COST_W'(q2_prod >> RECIP_REM_SH);
        end
    end

    assign done = vld_reg[4];
    assign cost = cost_reg;
endmodule
`default_nettype wire

// ===== hdl/mlfq_process_scheduler_unit.sv =====
`default_nettype none
// Channel  | Ports      | Word layout (low bit first)
// ---------+------------+----------------------------------------------------
// in       | s_t*       | tuser: action; tdata: proc_slot, is_realtime,
//          |            |   outcome, percent_used
// out      | m_t*       | tuser: status; tdata: slot_out, level_out, cost_ns,
//          |            |   cpu_time_ns, clock_ns
// config   | APB        | reg 0 @0x0: base_quantum_ns
//
// One word at a time. Admit and errors go straight to finish; io done reads the
// slot table, dispatch a ready FIFO then the table, slice the table then the cost
// unit; both RAMs read registered; the 5-stage cost unit uses multiply/reciprocal.
// s_tready drops from acceptance until the result enters the output register;
// a stalled m_tready holds the finish step, and once the result sits in the
// output register the next word is taken while it waits there.
// Reset (aresetn, synchronous) clears control state; no clearing pass.
module mlfq_process_scheduler_unit
    import mlfq_pkg::*;
#(
    parameter int NUM_SLOTS = 32
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [15:0]  s_tdata,   // proc_slot[4:0], is_realtime[5], outcome[7:6],
                                    // percent_used[14:8]
    input  wire  [1:0]   s_tuser,   // action[1:0]
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [151:0] m_tdata,   // slot_out[4:0], level_out[6:5], cost_ns[35:7],
                                    // cpu_time_ns[83:36], clock_ns[146:84]
    output logic [2:0]   m_tuser,   // status[2:0]
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int SW     = $clog2(NUM_SLOTS);
    localparam int CW     = $clog2(NUM_SLOTS + 1);
    localparam int FA_W   = $clog2(NUM_LEVELS * NUM_SLOTS);
    localparam int SRAM_W = CPU_W + LVL_W + 1;

    // ---- configuration ----
    logic [BASE_W-1:0] base_reg;
    logic              cfg_wr;
    logic [BASE_W-1:0] base_sat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == 1'b0) ? 32'(base_reg) : 32'd0;
    assign base_sat = (base_reg > BASE_MAX) ? BASE_MAX : base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else if (cfg_wr && paddr[2] == 1'b0) begin
            base_reg <= pwdata[BASE_W-1:0];
        end
    end

    // ---- input word fields ----
    action_t          in_act;
    logic [4:0]       in_slot;
    logic             in_rt;
    logic [1:0]       in_oc;
    logic [PCT_W-1:0] in_pct;
    logic [PCT_W-1:0] pct_sat;

    assign in_act  = action_t'(s_tuser);
    assign in_slot = s_tdata[4:0];
    assign in_rt   = s_tdata[5];
    assign in_oc   = s_tdata[7:6];
    assign in_pct  = s_tdata[14:8];
    assign pct_sat = (in_pct > PCT_MAX) ? PCT_MAX : in_pct;

    // ---- state ----
    fsm_t             state_reg, state_next;
    action_t          act_reg;
    logic [1:0]       oc_reg;
    logic [PCT_W-1:0] pct_reg;
    logic             rt_reg;
    logic [SW-1:0]    slot_reg;
    logic [LVL_W-1:0] lvl_reg;
    status_t          stat_reg;

    logic [NUM_SLOTS-1:0] in_use_reg;
    logic [NUM_SLOTS-1:0] blocked_reg;
    logic [SW-1:0]        head_reg  [NUM_LEVELS];
    logic [CW-1:0]        count_reg [NUM_LEVELS];
    logic                 run_valid_reg;
    logic [SW-1:0]        run_slot_reg;
    logic [CLK_W-1:0]     clock_reg;

    logic              m_tvalid_reg;
    status_t           m_stat_reg;
    logic [4:0]        m_slot_reg;
    logic [LVL_W-1:0]  m_lvl_reg;
    logic [COST_W-1:0] m_cost_reg;
    logic [CPU_W-1:0]  m_cpu_reg;
    logic [CLK_W-1:0]  m_clock_reg;

    // ---- memories ----
    logic              sram_we, sram_re;
    logic [SW-1:0]     sram_waddr, sram_raddr;
    logic [SRAM_W-1:0] sram_wdata, sram_rdata;
    logic              fram_we, fram_re;
    logic [FA_W-1:0]   fram_waddr, fram_raddr;
    logic [SW-1:0]     fram_rdata;

    // slot table: {realtime, level, cpu time}
    mlfq_ram #(.WIDTH(SRAM_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (sram_we),
        .wr_addr (sram_waddr),
        .wr_data (sram_wdata),
        .rd_en   (sram_re),
        .rd_addr (sram_raddr),
        .rd_data (sram_rdata)
    );

    // ready FIFOs, one ring of NUM_SLOTS entries per level
    mlfq_ram #(.WIDTH(SW), .DEPTH(NUM_LEVELS * NUM_SLOTS)) u_fifo_ram (
        .aclk    (aclk),
        .wr_en   (fram_we),
        .wr_addr (fram_waddr),
        .wr_data (slot_reg),
        .rd_en   (fram_re),
        .rd_addr (fram_raddr),
        .rd_data (fram_rdata)
    );

    // ---- cost unit ----
    cost_req_t         cost_req;
    logic              cost_done;
    logic [COST_W-1:0] cost_out;

    mlfq_cost u_cost (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cost_req),
        .done    (cost_done),
        .cost    (cost_out)
    );

    // ---- decode at acceptance ----
    logic             accept;
    logic             free_found;
    logic [SW-1:0]    free_idx;
    logic             lvl_found;
    logic [LVL_W-1:0] lvl_sel;
    logic [SW-1:0]    io_idx;
    logic             io_ok;
    status_t          err;

    assign accept = s_tvalid && s_tready;
    assign io_idx = SW'(in_slot);
    assign io_ok  = (int'(in_slot) < NUM_SLOTS);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
        lvl_found = 1'b0;
        lvl_sel   = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (count_reg[i] != '0) begin
                lvl_found = 1'b1;
                lvl_sel   = LVL_W'(i);
            end
        end
    end

    always_comb begin
        err = STAT_OK;
        unique case (in_act)
            ACT_ADMIT: begin
                if (!free_found) err = STAT_FULL;
            end
            ACT_DISPATCH: begin
                if (run_valid_reg)   err = STAT_BUSY;
                else if (!lvl_found) err = STAT_NONE_READY;
            end
            ACT_SLICE: begin
                if (!run_valid_reg) err = STAT_NONE_RUN;
            end
            ACT_IODONE: begin
                if (!io_ok || !in_use_reg[io_idx]) err = STAT_BAD_SLOT;
                else if (!blocked_reg[io_idx])     err = STAT_NOT_BLOCKED;
            end
            default: err = STAT_OK;
        endcase
    end

    // ---- finish step ----
    logic [CPU_W-1:0]  r_cpu;
    logic [LVL_W-1:0]  r_lvl;
    logic              r_rt;
    logic [COST_W-1:0] cost_v;
    logic [CPU_W:0]    cpu_sum;
    logic [CPU_W-1:0]  cpu_new;
    logic [CLK_W:0]    clk_sum;
    logic [CLK_W-1:0]  clk_new;
    logic              fin_fire;
    logic              fin_ok;
    logic              push_en, pop_en;
    logic [LVL_W-1:0]  push_lvl;
    logic [LVL_W-1:0]  fin_lvl;
    logic [CPU_W-1:0]  fin_cpu;
    logic [SW:0]       push_sum;
    logic [SW-1:0]     push_pos;
    logic              push_room;

    assign r_cpu = sram_rdata[CPU_W-1:0];
    assign r_lvl = sram_rdata[CPU_W +: LVL_W];
    assign r_rt  = sram_rdata[SRAM_W-1];

    assign cost_v  = (act_reg == ACT_SLICE) ? cost_out : '0;
    assign cpu_sum = {1'b0, r_cpu} + (CPU_W+1)'(cost_v);
    assign cpu_new = cpu_sum[CPU_W] ? CPU_MAX : cpu_sum[CPU_W-1:0];
    assign clk_sum = {1'b0, clock_reg} + (CLK_W+1)'(cost_v);
    assign clk_new = clk_sum[CLK_W] ? CLK_MAX : clk_sum[CLK_W-1:0];
    assign fin_ok  = (stat_reg == STAT_OK);

    always_comb begin
        push_en    = 1'b0;
        pop_en     = 1'b0;
        push_lvl   = '0;
        fin_lvl    = '0;
        fin_cpu    = '0;
        sram_wdata = '0;
        unique case (act_reg)
            ACT_ADMIT: begin
                fin_lvl    = rt_reg ? 2'd0 : 2'd1;
                push_en    = 1'b1;
                push_lvl   = fin_lvl;
                sram_wdata = {rt_reg, fin_lvl, {CPU_W{1'b0}}};
            end
            ACT_DISPATCH: begin
                fin_lvl    = lvl_reg;
                fin_cpu    = r_cpu;
                pop_en     = 1'b1;
                sram_wdata = {r_rt, lvl_reg, r_cpu};
            end
            ACT_SLICE: begin
                fin_cpu = cpu_new;
                if (oc_reg == OC_WHOLE) begin
                    // demote middle levels, top and bottom stay put
                    fin_lvl  = (r_lvl == 2'd1 || r_lvl == 2'd2) ? r_lvl + 2'd1 : r_lvl;
                    push_en  = 1'b1;
                    push_lvl = fin_lvl;
                end else begin
                    fin_lvl = r_lvl;
                end
                sram_wdata = {r_rt, fin_lvl, cpu_new};
            end
            ACT_IODONE: begin
                fin_lvl    = r_rt ? 2'd0 : 2'd1;
                fin_cpu    = r_cpu;
                push_en    = 1'b1;
                push_lvl   = fin_lvl;
                sram_wdata = {r_rt, fin_lvl, r_cpu};
            end
            default: ;
        endcase
    end

    assign push_sum  = (SW+1)'(head_reg[push_lvl]) + (SW+1)'(count_reg[push_lvl]);
    assign push_pos  = (push_sum >= (SW+1)'(NUM_SLOTS)) ? SW'(push_sum - (SW+1)'(NUM_SLOTS))
                                                        : SW'(push_sum);
    assign push_room = (count_reg[push_lvl] != CW'(NUM_SLOTS));

    // ---- FSM ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        fin_fire       = 1'b0;
        sram_re        = 1'b0;
        sram_raddr     = '0;
        fram_re        = 1'b0;
        fram_raddr     = FA_W'(lvl_sel) * FA_W'(NUM_SLOTS) + FA_W'(head_reg[lvl_sel]);
        cost_req       = '0;
        cost_req.whole = (oc_reg == OC_WHOLE);
        cost_req.lvl   = r_lvl;
        cost_req.pct   = pct_reg;
        cost_req.base  = base_sat;
        unique case (state_reg)
            FSM_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    if (err != STAT_OK || in_act == ACT_ADMIT) begin
                        state_next = FSM_FIN;
                    end else if (in_act == ACT_DISPATCH) begin
                        fram_re    = 1'b1;
                        state_next = FSM_FIFO;
                    end else begin
                        sram_re    = 1'b1;
                        sram_raddr = (in_act == ACT_SLICE) ? run_slot_reg : io_idx;
                        state_next = FSM_SLOT;
                    end
                end
            end
            FSM_FIFO: begin
                sram_re    = 1'b1;
                sram_raddr = fram_rdata;
                state_next = FSM_SLOT;
            end
            FSM_SLOT: begin
                if (act_reg == ACT_SLICE) begin
                    cost_req.start = 1'b1;
                    state_next     = FSM_COST;
                end else begin
                    state_next = FSM_FIN;
                end
            end
            FSM_COST: begin
                if (cost_done) state_next = FSM_FIN;
            end
            FSM_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    fin_fire   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    assign sram_we    = fin_fire && fin_ok;
    assign sram_waddr = slot_reg;
    assign fram_we    = fin_fire && fin_ok && push_en && push_room;
    assign fram_waddr = FA_W'(push_lvl) * FA_W'(NUM_SLOTS) + FA_W'(push_pos);

    // ---- per-word context ----
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg  <= in_act;
            oc_reg   <= in_oc;
            pct_reg  <= pct_sat;
            rt_reg   <= in_rt;
            stat_reg <= err;
            lvl_reg  <= lvl_sel;
            unique case (in_act)
                ACT_ADMIT:  slot_reg <= free_idx;
                ACT_SLICE:  slot_reg <= run_slot_reg;
                ACT_IODONE: slot_reg <= io_idx;
                default:    slot_reg <= slot_reg;
            endcase
        end else if (state_reg == FSM_FIFO) begin
            slot_reg <= fram_rdata;
        end
    end

    // ---- scheduler control state ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg    <= '0;
            blocked_reg   <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            clock_reg     <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else if (fin_fire && fin_ok) begin
            clock_reg <= clk_new;
            if (push_en && push_room) begin
                count_reg[push_lvl] <= count_reg[push_lvl] + CW'(1);
            end
            if (pop_en) begin
                head_reg[lvl_reg]  <= (head_reg[lvl_reg] == SW'(NUM_SLOTS - 1)) ? '0
                                      : head_reg[lvl_reg] + SW'(1);
                count_reg[lvl_reg] <= count_reg[lvl_reg] - CW'(1);
            end
            unique case (act_reg)
                ACT_ADMIT: begin
                    in_use_reg[slot_reg]  <= 1'b1;
                    blocked_reg[slot_reg] <= 1'b0;
                end
                ACT_DISPATCH: begin
                    run_valid_reg <= 1'b1;
                    run_slot_reg  <= slot_reg;
                end
                ACT_SLICE: begin
                    run_valid_reg <= 1'b0;
                    if (oc_reg == OC_TERM) begin
                        in_use_reg[slot_reg]  <= 1'b0;
                        blocked_reg[slot_reg] <= 1'b0;
                    end else if (oc_reg != OC_WHOLE) begin
                        blocked_reg[slot_reg] <= 1'b1;
                    end
                end
                ACT_IODONE: blocked_reg[slot_reg] <= 1'b0;
                default: ;
            endcase
        end
    end

    // ---- output register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fin_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_fire) begin
            m_stat_reg  <= stat_reg;
            m_slot_reg  <= fin_ok ? 5'(slot_reg) : '0;
            m_lvl_reg   <= fin_ok ? fin_lvl : '0;
            m_cost_reg  <= fin_ok ? cost_v : '0;
            m_cpu_reg   <= fin_ok ? fin_cpu : '0;
            m_clock_reg <= fin_ok ? clk_new : clock_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tdata  = {5'd0, m_clock_reg, m_cpu_reg, m_cost_reg, m_lvl_reg, m_slot_reg};
endmodule
`default_nettype wire

// ===== hdl/mlfq_chk.sv =====
`default_nettype none
module mlfq_chk
    import mlfq_pkg::*;
(
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [151:0] m_tdata,
    input wire [2:0]   m_tuser
);
    // one word in flight: no second word right behind an accepted one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= STAT_BAD_SLOT)
        else $error("status code out of range");

    // failed requests report nothing but the clock
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[83:0] == 84'd0)
        else $error("error word carries payload");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");
endmodule

bind mlfq_process_scheduler_unit mlfq_chk u_mlfq_chk (.*);
`default_nettype wire

// ===== verif/mlfq_process_scheduler_unit_tb.sv =====
`default_nettype none
module mlfq_process_scheduler_unit_tb;
    import mlfq_pkg::*;

    localparam int SLOTS = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 16;        // margin over the time a slice report takes
    localparam int RAND_PER_PHASE = 310;
    localparam int N_PHASES = 5;

    // outcome codes beyond the two the package names
    localparam logic [1:0] OC_PART  = 2'd2;
    localparam logic [1:0] OC_THREE = 2'd3;   // handled as a partial report

    localparam logic [2:0] REG_BASE = 3'd0;

    typedef struct {
        action_t    act;
        logic [4:0] pslot;
        logic       rt;
        logic [1:0] oc;
        logic [6:0] pct;
    } sched_req_t;

    typedef struct {
        status_t     status;
        logic [4:0]  slot;
        logic [1:0]  lvl;
        logic [28:0] cost;
        logic [47:0] cpu;
        logic [62:0] clk;
    } sched_resp_t;

    // one row of the directed table; typed rows carry a hand-written answer
    typedef struct {
        sched_req_t  req;
        bit          typed;
        sched_resp_t resp;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [15:0]  s_tdata = '0;   // proc_slot[4:0], is_realtime[5], outcome[7:6], pct[14:8]
    logic [1:0]   s_tuser = '0;   // action[1:0]
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [151:0] m_tdata;        // slot[4:0], level[6:5], cost[35:7], cpu[83:36], clk[146:84]
    wire  [2:0]   m_tuser;        // status[2:0]
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    wire  [31:0]  prdata;
    wire          pready;

    mlfq_process_scheduler_unit #(.NUM_SLOTS(SLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // ---- scheduler mirror: slot table, per-level ready rings, clock ----
    logic [26:0] quantum;
    bit          in_use [SLOTS];
    bit          is_rt [SLOTS];
    bit          blocked [SLOTS];
    logic [1:0]  lvl_of [SLOTS];
    logic [47:0] cpu_of [SLOTS];
    logic [4:0]  ring [NUM_LEVELS][SLOTS];
    int          ring_head [NUM_LEVELS];
    int          ring_cnt [NUM_LEVELS];
    bit          have_running;
    logic [4:0]  running;
    logic [63:0] sys_clk;

    sched_resp_t pending_results[$];
    int          errors = 0;
    int          words_sent = 0;
    int          burst_left = 0;
    bit          long_hold = 1'b0;
    int          cycles = 0;

    task automatic mirror_reset();
        quantum = BASE_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            in_use[i] = 0; is_rt[i] = 0; blocked[i] = 0; lvl_of[i] = 0; cpu_of[i] = 0;
        end
        for (int l = 0; l < NUM_LEVELS; l++) begin
            ring_head[l] = 0; ring_cnt[l] = 0;
        end
        have_running = 0;
        running = 0;
        sys_clk = 0;
    endtask

    task automatic enqueue_ready(input logic [1:0] l, input logic [4:0] s);
        if (ring_cnt[l] < SLOTS) begin
            ring[l][(ring_head[l] + ring_cnt[l]) % SLOTS] = s;
            ring_cnt[l]++;
        end
    endtask

    task automatic add_charge(input logic [4:0] s, input logic [63:0] c);
        logic [63:0] acc;
        acc = {16'd0, cpu_of[s]} + c;
        cpu_of[s] = (acc > {16'd0, CPU_MAX}) ? CPU_MAX : acc[47:0];
        acc = sys_clk + c;
        sys_clk = (acc > {1'b0, CLK_MAX}) ? {1'b0, CLK_MAX} : acc;
    endtask

    task automatic schedule_step(input sched_req_t r, output sched_resp_t o);
        logic [6:0]  pct;
        logic [63:0] base, whole, cost;
        logic [1:0]  l;
        logic [4:0]  s;
        logic [47:0] cpu;
        status_t     st;
        bit          found;
        pct = (r.pct > PCT_MAX) ? PCT_MAX : r.pct;
        st = STAT_OK; s = 0; l = 0; cost = 0; cpu = 0; found = 0;
        case (r.act)
            ACT_ADMIT: begin
                for (int i = 0; i < SLOTS; i++)
                    if (!found && !in_use[i]) begin
                        found = 1; s = i[4:0];
                    end
                if (!found) begin
                    st = STAT_FULL;
                end else begin
                    l = r.rt ? 2'd0 : 2'd1;
                    in_use[s] = 1; is_rt[s] = r.rt; blocked[s] = 0;
                    cpu_of[s] = 0; lvl_of[s] = l;
                    enqueue_ready(l, s);
                end
            end
            ACT_DISPATCH: begin
                if (have_running) begin
                    st = STAT_BUSY;
                end else begin
                    for (int i = 0; i < NUM_LEVELS; i++)
                        if (!found && ring_cnt[i] != 0) begin
                            found = 1; l = i[1:0];
                        end
                    if (!found) begin
                        st = STAT_NONE_READY;
                    end else begin
                        s = ring[l][ring_head[l]];
                        ring_head[l] = (ring_head[l] + 1) % SLOTS;
                        ring_cnt[l]--;
                        lvl_of[s] = l;
                        have_running = 1;
                        running = s;
                        cpu = cpu_of[s];
                    end
                end
            end
            ACT_SLICE: begin
                if (!have_running) begin
                    st = STAT_NONE_RUN;
                end else begin
                    base = (quantum > BASE_MAX) ? 64'(BASE_MAX) : 64'(quantum);
                    s = running;
                    l = lvl_of[s];
                    whole = base * (64'(l) + 64'd1);
                    have_running = 0;
                    if (r.oc == OC_WHOLE) begin
                        cost = whole;
                        add_charge(s, cost);
                        if (l == 2'd1 || l == 2'd2) l = l + 2'd1;   // demote one level
                        lvl_of[s] = l;
                        enqueue_ready(l, s);
                    end else begin
                        cost = whole * 64'(pct) / 64'd100;
                        add_charge(s, cost);
                        if (r.oc == OC_TERM) begin
                            in_use[s] = 0; blocked[s] = 0;
                        end else begin
                            blocked[s] = 1;
                        end
                    end
                    cpu = cpu_of[s];
                end
            end
            default: begin   // io done
                if (!in_use[r.pslot]) begin
                    st = STAT_BAD_SLOT;
                end else if (!blocked[r.pslot]) begin
                    st = STAT_NOT_BLOCKED;
                end else begin
                    s = r.pslot;
                    l = is_rt[s] ? 2'd0 : 2'd1;
                    blocked[s] = 0;
                    lvl_of[s] = l;
                    enqueue_ready(l, s);
                    cpu = cpu_of[s];
                end
            end
        endcase
        if (st != STAT_OK) begin
            s = 0; l = 0; cost = 0; cpu = 0;
        end
        o.status = st; o.slot = s; o.lvl = l; o.cost = cost[28:0]; o.cpu = cpu;
        o.clk = sys_clk[62:0];
    endtask

    // ---- input side: bursts with random gaps; mirror runs on acceptance ----
    task automatic send_word(input sched_req_t r, input bit typed, input sched_resp_t hand);
        sched_resp_t e;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.act;
        s_tdata  <= {1'b0, r.pct, r.oc, r.rt, r.pslot};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        words_sent++;
        schedule_step(r, e);
        if (typed) begin
            hand.clk = e.clk;   // clock is taken from the mirror even on typed rows
            e = hand;
        end
        pending_results.push_back(e);
    endtask

    // register writes only with nothing in flight
    task automatic write_quantum(input logic [31:0] v);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= REG_BASE; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        quantum = v[26:0];
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic sched_req_t random_req(input int admit_pct);
        sched_req_t r;
        int         pick, cands[$];
        pick = $urandom_range(0, 99);
        r.pslot = 5'($urandom_range(0, 31));
        r.rt = 1'($urandom_range(0, 1));
        r.pct = 7'($urandom_range(0, 127));
        r.oc = ($urandom_range(0, 5) == 0) ? OC_TERM : 2'($urandom_range(1, 3));
        if (pick < admit_pct) r.act = ACT_ADMIT;
        else if (pick < admit_pct + 30) r.act = ACT_DISPATCH;
        else if (pick < admit_pct + 62) r.act = ACT_SLICE;
        else r.act = ACT_IODONE;
        if (r.act == ACT_IODONE && $urandom_range(0, 9) < 7) begin
            for (int i = 0; i < SLOTS; i++) if (blocked[i]) cands.push_back(i);
            if (cands.size() != 0) r.pslot = 5'(cands[$urandom_range(0, cands.size() - 1)]);
        end
        return r;
    endfunction

    function automatic dir_row_t row(input action_t a, input logic [4:0] ps, input logic rt,
                                     input logic [1:0] oc, input logic [6:0] pct);
        dir_row_t d;
        d.req.act = a; d.req.pslot = ps; d.req.rt = rt; d.req.oc = oc; d.req.pct = pct;
        d.typed = 0;
        d.resp.status = STAT_OK; d.resp.slot = 0; d.resp.lvl = 0; d.resp.cost = 0;
        d.resp.cpu = 0; d.resp.clk = 0;
        return d;
    endfunction

    function automatic dir_row_t typed_row(input dir_row_t d, input status_t st,
                                           input logic [4:0] s, input logic [1:0] l,
                                           input logic [28:0] c, input logic [47:0] cpu);
        d.typed = 1;
        d.resp.status = st; d.resp.slot = s; d.resp.lvl = l; d.resp.cost = c; d.resp.cpu = cpu;
        return d;
    endfunction

    // ---- stimulus ----
    initial begin
        dir_row_t    dir[$];
        logic [31:0] settings [N_PHASES];
        sched_req_t  r;
        mirror_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty scheduler errors, then a life cycle through every level
        dir.push_back(typed_row(row(ACT_DISPATCH, 0, 0, 0, 0), STAT_NONE_READY, 0, 0, 0, 0));
        dir.push_back(typed_row(row(ACT_SLICE, 0, 0, OC_WHOLE, 0), STAT_NONE_RUN, 0, 0, 0, 0));
        dir.push_back(typed_row(row(ACT_IODONE, 31, 1, 0, 0), STAT_BAD_SLOT, 0, 0, 0, 0));
        dir.push_back(typed_row(row(ACT_ADMIT, 0, 1, 0, 0), STAT_OK, 0, 0, 0, 0));
        dir.push_back(typed_row(row(ACT_ADMIT, 0, 0, 0, 0), STAT_OK, 1, 1, 0, 0));
        dir.push_back(typed_row(row(ACT_DISPATCH, 0, 0, 0, 0), STAT_OK, 0, 0, 0, 0));
        dir.push_back(typed_row(row(ACT_DISPATCH, 0, 0, 0, 0), STAT_BUSY, 0, 0, 0, 0));
        dir.push_back(typed_row(row(ACT_SLICE, 0, 0, OC_WHOLE, 127), STAT_OK, 0, 0,
                                29'd10000000, 48'd10000000));
        dir.push_back(row(ACT_DISPATCH, 0, 0, 0, 0));
        dir.push_back(row(ACT_SLICE, 0, 0, OC_PART, 127));     // percent saturates
        dir.push_back(row(ACT_IODONE, 0, 0, 0, 0));
        dir.push_back(row(ACT_IODONE, 0, 0, 0, 0));             // no longer blocked
        dir.push_back(row(ACT_DISPATCH, 0, 0, 0, 0));
        dir.push_back(row(ACT_SLICE, 0, 0, OC_THREE, 50));
        dir.push_back(row(ACT_IODONE, 1, 0, 0, 0));             // in use, not blocked
        dir.push_back(row(ACT_DISPATCH, 0, 0, 0, 0));
        dir.push_back(row(ACT_SLICE, 0, 0, OC_WHOLE, 0));       // level 1 to 2
        dir.push_back(row(ACT_DISPATCH, 0, 0, 0, 0));
        dir.push_back(row(ACT_SLICE, 0, 0, OC_WHOLE, 0));       // 2 to 3
        dir.push_back(row(ACT_DISPATCH, 0, 0, 0, 0));
        dir.push_back(row(ACT_SLICE, 0, 0, OC_WHOLE, 100));     // 3 stays
        dir.push_back(row(ACT_DISPATCH, 0, 0, 0, 0));
        dir.push_back(row(ACT_SLICE, 0, 0, OC_TERM, 99));
        dir.push_back(row(ACT_IODONE, 1, 0, 0, 0));             // freed slot
        dir.push_back(row(ACT_SLICE, 0, 0, OC_TERM, 0));

        foreach (dir[i]) send_word(dir[i].req, dir[i].typed, dir[i].resp);

        // quantum: minimum, maximum, above range (saturates), zero, random
        settings[0] = 32'd1;
        settings[1] = 32'd100000000;
        settings[2] = 32'hFFFF_FFFF;
        settings[3] = 32'd0;
        settings[4] = $urandom_range(1, 100000000);
        for (int p = 0; p < N_PHASES; p++) begin
            write_quantum(settings[p]);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                // every other phase leans on admits so the table fills up
                r = random_req((p % 2 == 1) ? 45 : 22);
                send_word(r, 0, dir[0].resp);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ---- output side: changing stall pattern plus one long hold ----
    always @(posedge aclk) begin
        case (cycles[8:7])
            2'd0: m_tready <= !long_hold;
            2'd1: m_tready <= !long_hold && ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= !long_hold && ($urandom_range(0, 3) == 0);
            default: m_tready <= !long_hold && cycles[1];
        endcase
    end

    initial begin
        wait (words_sent >= 700);
        long_hold = 1'b1;
        repeat (400) @(posedge aclk);
        long_hold = 1'b0;
    end

    always @(posedge aclk) begin
        sched_resp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word status=%0d data=%h", $time, m_tuser, m_tdata);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_tuser !== e.status || m_tdata[4:0] !== e.slot || m_tdata[6:5] !== e.lvl
                    || m_tdata[35:7] !== e.cost || m_tdata[83:36] !== e.cpu
                    || m_tdata[146:84] !== e.clk) begin
                    $display("%0t: expected st=%0d slot=%0d lvl=%0d cost=%0d cpu=%0d clk=%0d",
                             $time, e.status, e.slot, e.lvl, e.cost, e.cpu, e.clk);
                    $display("%0t: actual   st=%0d slot=%0d lvl=%0d cost=%0d cpu=%0d clk=%0d",
                             $time, m_tuser, m_tdata[4:0], m_tdata[6:5], m_tdata[35:7],
                             m_tdata[83:36], m_tdata[146:84]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/mlfq_pkg.sv
hdl/mlfq_ram.sv
hdl/mlfq_cost.sv
hdl/mlfq_process_scheduler_unit.sv
hdl/mlfq_chk.sv
verif/mlfq_process_scheduler_unit_tb.sv
